[hdl/assert_macros.svh]
// Assertion helpers for the checker file of this block.
// Every macro samples on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only while reset is released.
`define BWEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define BWEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/bwec_pkg.sv]
`default_nettype none

package bwec_pkg;

  // Ring of stamped bumps.
  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  // Field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SIDE_W     = 2;
  localparam int unsigned BTT_W      = 5;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned SPEED_W    = 15;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CMP_W      = (CNT_W > BTT_W) ? CNT_W : BTT_W;

  localparam logic [RING_AW-1:0] LAST_SLOT  = RING_AW'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(RING_DEPTH);

  // Input opcodes.
  localparam logic OP_BUMP = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Bumper sides that steer the turn.
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUMPS_TO_TRIGGER = 3'd0,
    CFG_WINDOW_TICKS     = 3'd1,
    CFG_HOLDOFF_TICKS    = 3'd2,
    CFG_EVADE_TICKS      = 3'd3,
    CFG_REVERSE_SPEED    = 3'd4,
    CFG_TURN_SPEED       = 3'd5
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [BTT_W-1:0]   BTT_RST     = 5'd2;
  localparam logic [TICKS_W-1:0] WINDOW_RST  = 16'd300;
  localparam logic [TICKS_W-1:0] HOLDOFF_RST = 16'd300;
  localparam logic [TICKS_W-1:0] EVADE_RST   = 16'd50;
  localparam logic [SPEED_W-1:0] REVERSE_RST = 15'd3277;
  localparam logic [SPEED_W-1:0] TURN_RST    = 15'd2458;

  typedef struct packed {
    logic [BTT_W-1:0]   bumps_to_trigger;
    logic [TICKS_W-1:0] window_ticks;
    logic [TICKS_W-1:0] holdoff_ticks;
    logic [TICKS_W-1:0] evade_ticks;
    logic [SPEED_W-1:0] reverse_speed;
    logic [SPEED_W-1:0] turn_speed;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [SIDE_W-1:0] bump_side;
    logic              bump_pressed;
  } in_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] linear_cmd;
    logic signed [CMD_W-1:0] angular_cmd;
  } out_t;

  // One ring entry: tick stamp and bumper side.
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [SIDE_W-1:0] side;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_CMD
  } state_e;

endpackage

`default_nettype wire

[hdl/bwec_ram.sv]
`default_nettype none

module bwec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/bwec_cfg.sv]
`default_nettype none

module bwec_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bwec_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [bwec_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output bwec_pkg::cfg_t                           cfg_o
);

  bwec_pkg::cfg_t cfg_q;

  // Register bank; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bumps_to_trigger <= bwec_pkg::BTT_RST;
      cfg_q.window_ticks     <= bwec_pkg::WINDOW_RST;
      cfg_q.holdoff_ticks    <= bwec_pkg::HOLDOFF_RST;
      cfg_q.evade_ticks      <= bwec_pkg::EVADE_RST;
      cfg_q.reverse_speed    <= bwec_pkg::REVERSE_RST;
      cfg_q.turn_speed       <= bwec_pkg::TURN_RST;
    end else if (cfg_we_i) begin
      case (bwec_pkg::cfg_idx_e'(cfg_idx_i))
        bwec_pkg::CFG_BUMPS_TO_TRIGGER: begin
          cfg_q.bumps_to_trigger <= cfg_wdata_i[bwec_pkg::BTT_W-1:0];
        end
        bwec_pkg::CFG_WINDOW_TICKS: begin
          cfg_q.window_ticks <= cfg_wdata_i[bwec_pkg::TICKS_W-1:0];
        end
        bwec_pkg::CFG_HOLDOFF_TICKS: begin
          cfg_q.holdoff_ticks <= cfg_wdata_i[bwec_pkg::TICKS_W-1:0];
        end
        bwec_pkg::CFG_EVADE_TICKS: begin
          cfg_q.evade_ticks <= cfg_wdata_i[bwec_pkg::TICKS_W-1:0];
        end
        bwec_pkg::CFG_REVERSE_SPEED: begin
          cfg_q.reverse_speed <= cfg_wdata_i[bwec_pkg::SPEED_W-1:0];
        end
        bwec_pkg::CFG_TURN_SPEED: begin
          cfg_q.turn_speed <= cfg_wdata_i[bwec_pkg::SPEED_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/bwec_ctrl.sv]
`default_nettype none

module bwec_ctrl (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bwec_pkg::cfg_t                       cfg_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire bwec_pkg::in_t                        in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output bwec_pkg::out_t                            out_data_o,
  output logic                                      ram_we_o,
  output logic [bwec_pkg::RING_AW-1:0]              ram_waddr_o,
  output bwec_pkg::entry_t                          ram_wdata_o,
  output logic                                      ram_re_o,
  output logic [bwec_pkg::RING_AW-1:0]              ram_raddr_o,
  input  wire bwec_pkg::entry_t                     ram_rdata_i
);

  bwec_pkg::state_e                   state_q, state_d;
  logic [bwec_pkg::TIME_W-1:0]        tick_q, tick_d;
  logic [bwec_pkg::RING_AW-1:0]       head_q, head_d;
  logic [bwec_pkg::CNT_W-1:0]         count_q, count_d;
  logic                               evading_q, evading_d;
  logic [bwec_pkg::TIME_W-1:0]        start_q, start_d;
  logic [bwec_pkg::TIME_W-1:0]        end_q, end_d;
  logic                               out_valid_q, out_valid_d;
  bwec_pkg::out_t                     out_q, out_d;

  logic                               in_acc;
  logic                               is_tick;
  logic                               is_bump;
  logic [bwec_pkg::TIME_W-1:0]        tick_now;
  logic                               in_window;
  logic                               holdoff_done;
  logic                               count_zero;
  logic                               aged;
  logic                               trig;
  logic                               out_free;
  logic [bwec_pkg::RING_AW-1:0]       head_inc;
  logic [bwec_pkg::RING_AW-1:0]       last_slot;
  logic [bwec_pkg::SUM_W-1:0]         old_sum;
  logic [bwec_pkg::RING_AW-1:0]       oldest;

  // Items are taken only between operations; the ring is never read and
  // written in the same cycle, so no forwarding is needed.
  assign in_acc   = in_valid_i && (state_q == bwec_pkg::ST_IDLE);
  assign is_tick  = in_data_i.opcode == bwec_pkg::OP_TICK;
  assign is_bump  = in_data_i.opcode == bwec_pkg::OP_BUMP;
  assign tick_now = tick_q + bwec_pkg::TIME_W'(1);

  // Modular time comparisons against the configured spans.
  assign in_window    = (tick_now - start_q) <= bwec_pkg::TIME_W'(cfg_i.evade_ticks);
  assign holdoff_done = (tick_now - end_q) > bwec_pkg::TIME_W'(cfg_i.holdoff_ticks);
  assign aged = (tick_q - ram_rdata_i.stamp) > bwec_pkg::TIME_W'(cfg_i.window_ticks);

  assign count_zero = count_q == '0;
  assign trig = bwec_pkg::CMP_W'(count_q) >= bwec_pkg::CMP_W'(cfg_i.bumps_to_trigger);
  assign out_free = !out_valid_q || !out_stall_i;

  // Ring slot arithmetic for any depth.
  assign head_inc  = (head_q == bwec_pkg::LAST_SLOT) ? '0 : head_q + bwec_pkg::RING_AW'(1);
  assign last_slot = (head_q == '0) ? bwec_pkg::LAST_SLOT : head_q - bwec_pkg::RING_AW'(1);
  assign old_sum = bwec_pkg::SUM_W'(head_q) + bwec_pkg::SUM_W'(bwec_pkg::RING_DEPTH)
                 - bwec_pkg::SUM_W'(count_q);
  assign oldest  = (old_sum >= bwec_pkg::SUM_W'(bwec_pkg::RING_DEPTH))
                 ? bwec_pkg::RING_AW'(old_sum - bwec_pkg::SUM_W'(bwec_pkg::RING_DEPTH))
                 : bwec_pkg::RING_AW'(old_sum);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bwec_pkg::ST_IDLE: begin
        if (in_acc && is_tick) begin
          if (evading_q) begin
            state_d = in_window ? bwec_pkg::ST_CMD : bwec_pkg::ST_IDLE;
          end else begin
            state_d = holdoff_done ? bwec_pkg::ST_PRUNE_RD : bwec_pkg::ST_IDLE;
          end
        end
      end
      bwec_pkg::ST_PRUNE_RD: begin
        state_d = count_zero ? bwec_pkg::ST_IDLE : bwec_pkg::ST_PRUNE_CHK;
      end
      bwec_pkg::ST_PRUNE_CHK: begin
        state_d = aged ? bwec_pkg::ST_PRUNE_RD : bwec_pkg::ST_IDLE;
      end
      bwec_pkg::ST_CMD: begin
        state_d = out_free ? bwec_pkg::ST_IDLE : bwec_pkg::ST_CMD;
      end
      default: begin
        state_d = bwec_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, ring accesses and result register.
  always_comb begin
    tick_d      = tick_q;
    head_d      = head_q;
    count_d     = count_q;
    evading_d   = evading_q;
    start_d     = start_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;
    ram_wdata_o.stamp = tick_q;
    ram_wdata_o.side  = in_data_i.bump_side;
    ram_re_o    = 1'b0;
    ram_raddr_o = oldest;

    case (state_q)
      bwec_pkg::ST_IDLE: begin
        if (in_acc && is_bump && in_data_i.bump_pressed) begin
          // Store the bump at the head, overwriting the oldest when full.
          ram_we_o = 1'b1;
          head_d   = head_inc;
          if (count_q != bwec_pkg::FULL_COUNT) begin
            count_d = count_q + bwec_pkg::CNT_W'(1);
          end
        end else if (in_acc && is_tick) begin
          tick_d = tick_now;
          if (evading_q) begin
            if (in_window) begin
              // Fetch the newest bump to choose the turn direction.
              ram_re_o    = 1'b1;
              ram_raddr_o = last_slot;
            end else begin
              evading_d = 1'b0;
              end_d     = tick_now;
            end
          end
        end
      end
      bwec_pkg::ST_PRUNE_RD: begin
        if (count_zero) begin
          if (trig) begin
            evading_d = 1'b1;
            start_d   = tick_q;
          end
        end else begin
          ram_re_o = 1'b1;
        end
      end
      bwec_pkg::ST_PRUNE_CHK: begin
        if (aged) begin
          count_d = count_q - bwec_pkg::CNT_W'(1);
        end else if (trig) begin
          evading_d = 1'b1;
          start_d   = tick_q;
        end
      end
      bwec_pkg::ST_CMD: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.linear_cmd  = $signed(bwec_pkg::CMD_W'(0)
                                      - bwec_pkg::CMD_W'(cfg_i.reverse_speed));
          out_d.angular_cmd = '0;
          if (!count_zero) begin
            if (ram_rdata_i.side == bwec_pkg::SIDE_LEFT) begin
              out_d.angular_cmd = $signed(bwec_pkg::CMD_W'(cfg_i.turn_speed));
            end else if (ram_rdata_i.side == bwec_pkg::SIDE_RIGHT) begin
              out_d.angular_cmd = $signed(bwec_pkg::CMD_W'(0)
                                          - bwec_pkg::CMD_W'(cfg_i.turn_speed));
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwec_pkg::ST_IDLE;
      tick_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      evading_q   <= 1'b0;
      start_q     <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      head_q      <= head_d;
      count_q     <= count_d;
      evading_q   <= evading_d;
      start_q     <= start_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = state_q != bwec_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hdl/bump_window_evade_controller_unit.sv]
`default_nettype none

// Bump window evade controller. Pressed bump beats are stamped with the tick
// count and kept in a ring memory of RING_DEPTH entries; tick beats drive an
// evade manoeuvre that reverses and turns away from the newest bump. A bump
// beat and a tick that neither triggers nor emits are absorbed without
// stalling the input. A tick inside the evade window reads the newest side
// from the ring and then waits until the result register can take the
// command, which out_stall_i may hold off. An idle tick past the holdoff
// checks the ring from the oldest entry, dropping aged entries until one is
// kept or the ring is empty; each examined entry costs one read of the ring
// memory's single read port and one compare. The ring needs no clearing
// after reset, and configuration may be written whenever the block is idle.
module bump_window_evade_controller_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bwec_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bwec_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire bwec_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output bwec_pkg::out_t                        out_data_o
);

  bwec_pkg::cfg_t                 cfg;
  logic                           ram_we;
  logic [bwec_pkg::RING_AW-1:0]   ram_waddr;
  bwec_pkg::entry_t               ram_wdata;
  logic                           ram_re;
  logic [bwec_pkg::RING_AW-1:0]   ram_raddr;
  logic [bwec_pkg::ENTRY_W-1:0]   ram_rdata;

  // Configuration registers.
  bwec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Ring of stamped bumps.
  bwec_ram #(
    .WIDTH (bwec_pkg::ENTRY_W),
    .DEPTH (bwec_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and result register.
  bwec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

`default_nettype wire

[hdl/bwec_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module bwec_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_we_i,
  input wire logic [bwec_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input wire logic [bwec_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire bwec_pkg::in_t                    in_data_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire bwec_pkg::out_t                   out_data_o
);

  // A stalled result beat stays offered and unchanged.
  `BWEC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "result beat dropped while stalled")
  `BWEC_ASSERT(a_out_stable, (out_valid_o && out_stall_i) |=> $stable(out_data_o), "stalled result beat changed")

  // A bump beat is absorbed without stalling, so the input is free right after.
  `BWEC_ASSERT(a_bump_one_cycle, (in_valid_i && !in_stall_o && in_data_i.opcode == bwec_pkg::OP_BUMP) |=> !in_stall_o, "input stalled after a bump beat")

  // Every delivered command drives backward or stands still.
  `BWEC_ASSERT(a_reverse_only, (out_valid_o && !out_stall_i) |-> out_data_o.linear_cmd <= 16'sd0, "forward linear command delivered")

  // Under reset no result is offered and the input is open.
  `BWEC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!out_valid_o && !in_stall_o), "outputs active during reset")

endmodule

bind bump_window_evade_controller_unit bwec_checker u_checker (.*);

`default_nettype wire
